>>> src/cma_pkg.sv
// cma_pkg: shared types and constants for the covariance matrix accumulator.
// Used by covariance_matrix_accumulator; no dependencies.
package cma_pkg;

    // Parameter defaults
    localparam int MAX_DIM_DEF     = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int IDX_FLD_W = 6;
    localparam int DIM_CFG_W = 7;
    localparam int SUM_W     = 64;
    localparam int CNT_W     = 32;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_DIM_IN_USE = 1'b0;   // word index of dim_in_use

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 7'd64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CLEAR,   // sweeping zeros through the sum store
        ST_IDLE,
        ST_READ,    // sum store data returning for a read
        ST_ROW,     // fetch x_i
        ST_XI,      // latch x_i
        ST_OPS,     // one multiply-accumulate issued per cycle
        ST_DRAIN    // let the last updates retire
    } state_t;

endpackage

>>> src/cma_ram.sv
// cma_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module cma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/covariance_matrix_accumulator.sv
// Covariance matrix accumulator: a push of a non-final sample leaves the block idle for the next
// word; the push that completes a vector of n samples keeps the block busy while the single
// multiply-accumulate pipe issues one sum update per cycle, with x_i fetched for each row
// first. A read returns its word through the sum store read register and then the output
// register, once the output is free. A clear, and the period after reset, sweeps the sum store
// one entry a cycle, during which no word is accepted. rst_n is asynchronous, active low.
module covariance_matrix_accumulator
    import cma_pkg::*;
#(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CMD_W-1:0]              command,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [IDX_FLD_W-1:0]          row,
    input  logic [IDX_FLD_W-1:0]          col,
    // result words
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SUM_W-1:0]       entry_value,
    output logic [CNT_W-1:0]              vectors_done,
    output logic                          overflow_seen,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_AW-1:0]             paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PROD_W = 2 * SAMPLE_BITS;

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
        return AW'(AW'(r) * AW'(MAX_DIM)) + AW'(c);
    endfunction

    state_t state_reg, state_next;

    logic [DIM_CFG_W-1:0]          dim_reg;
    logic [IDX_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          sticky_reg;
    logic [AW-1:0]                 clr_addr_reg;
    logic [IDX_W-1:0]              i_reg;
    logic [IDX_W-1:0]              j_reg;
    logic                          second_reg;
    logic signed [SAMPLE_BITS-1:0] xi_reg;
    logic                          s1_vld_reg;
    logic [AW-1:0]                 s1_addr_reg;
    logic                          s2_vld_reg;
    logic [AW-1:0]                 s2_addr_reg;
    logic signed [SUM_W-1:0]       prod_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic                          oob_reg;
    logic                          out_valid_reg;
    logic signed [SUM_W-1:0]       entry_reg;
    logic [CNT_W-1:0]              vdone_reg;
    logic                          ovf_reg;

    logic                          accept;
    logic                          cfg_write;
    logic [DIM_W-1:0]              act_n;
    logic [IDX_W-1:0]              fill_eff;
    logic                          push_last;
    logic                          row_done;
    logic                          last_row;
    logic                          read_oob;
    logic                          out_free;

    logic                          vb_we;
    logic [IDX_W-1:0]              vb_waddr;
    logic                          vb_re;
    logic [IDX_W-1:0]              vb_raddr;
    logic [SAMPLE_BITS-1:0]        vb_rdata;
    logic                          cov_we;
    logic [AW-1:0]                 cov_waddr;
    logic [SUM_W-1:0]              cov_wdata;
    logic                          cov_re;
    logic [AW-1:0]                 cov_raddr;
    logic [SUM_W-1:0]              cov_rdata;
    logic [AW-1:0]                 op_addr;

    logic signed [PROD_W-1:0]      mul;
    logic signed [SUM_W:0]         add_wide;
    logic signed [SUM_W-1:0]       add_sat;
    logic                          add_ovf;

    // ---------------------------------------------------------------- decode
    assign accept    = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_DIM_IN_USE) ? APB_DW'(dim_reg) : '0;

    always_comb
    begin
        if (dim_reg == '0)
            act_n = DIM_W'(1);
        else if (32'(dim_reg) > MAX_DIM)
            act_n = DIM_W'(MAX_DIM);
        else
            act_n = DIM_W'(dim_reg);
    end

    assign fill_eff  = (DIM_W'(fill_reg) >= act_n) ? '0 : fill_reg;
    assign push_last = (DIM_W'(fill_eff) + DIM_W'(1)) == act_n;
    assign row_done  = (j_reg == i_reg);
    assign last_row  = (DIM_W'(i_reg) + DIM_W'(1)) == act_n;
    assign read_oob  = (32'(row) >= MAX_DIM) || (32'(col) >= MAX_DIM);
    assign out_free  = !out_valid_reg || !out_stall;
    assign op_addr   = second_reg ? cell_addr(i_reg, j_reg) : cell_addr(j_reg, i_reg);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_PUSH:  state_next = push_last ? ST_ROW : ST_IDLE;
                        CMD_READ:  state_next = ST_READ;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_ROW:   state_next = ST_XI;
            ST_XI:    state_next = ST_OPS;
            ST_OPS:
            begin
                if (row_done)
                    state_next = last_row ? ST_DRAIN : ST_ROW;
            end
            ST_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs / memory control
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        vb_we     = 1'b0;
        vb_waddr  = fill_eff;
        vb_re     = 1'b0;
        vb_raddr  = j_reg;
        cov_re    = 1'b0;
        cov_raddr = op_addr;
        cov_we    = 1'b0;
        cov_waddr = s2_addr_reg;
        cov_wdata = add_sat;
        case (state_reg)
            ST_CLEAR:
            begin
                cov_we    = 1'b1;
                cov_waddr = clr_addr_reg;
                cov_wdata = '0;
            end
            ST_IDLE:
            begin
                vb_we     = accept && (command == CMD_PUSH);
                cov_re    = accept && (command == CMD_READ);
                cov_raddr = read_oob ? '0
                          : cell_addr(IDX_W'(row), IDX_W'(col));
            end
            ST_ROW:
            begin
                vb_re    = 1'b1;
                vb_raddr = i_reg;
                cov_we   = s2_vld_reg;
            end
            ST_OPS:
            begin
                vb_re  = 1'b1;
                cov_re = 1'b1;
                cov_we = s2_vld_reg;
            end
            ST_XI, ST_DRAIN:
            begin
                cov_we = s2_vld_reg;
            end
            default:
            begin
                cov_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- memories
    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vb_we),
        .waddr (vb_waddr),
        .wdata (sample),
        .re    (vb_re),
        .raddr (vb_raddr),
        .rdata (vb_rdata)
    );

    cma_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (cov_we),
        .waddr (cov_waddr),
        .wdata (cov_wdata),
        .re    (cov_re),
        .raddr (cov_raddr),
        .rdata (cov_rdata)
    );

    // ---------------------------------------------------------------- MAC datapath
    // stage 1: product of x_i and x_j off the RAM register; stage 2: saturating add
    assign mul      = xi_reg * $signed(vb_rdata);
    assign add_wide = {sum_reg[SUM_W-1], sum_reg} + {prod_reg[SUM_W-1], prod_reg};
    assign add_ovf  = add_wide[SUM_W] != add_wide[SUM_W-1];
    assign add_sat  = !add_ovf ? add_wide[SUM_W-1:0]
                    : (add_wide[SUM_W] ? SUM_MIN : SUM_MAX);

    always_ff @(posedge clk)
    begin
        prod_reg    <= SUM_W'(mul);
        sum_reg     <= cov_rdata;
        s1_addr_reg <= op_addr;
        s2_addr_reg <= s1_addr_reg;
        if (state_reg == ST_XI)
            xi_reg <= $signed(vb_rdata);
        if (state_reg == ST_IDLE)
            oob_reg <= read_oob;
        if ((state_reg == ST_READ) && out_free)
        begin
            entry_reg <= oob_reg ? '0 : cov_rdata;
            vdone_reg <= count_reg;
            ovf_reg   <= sticky_reg;
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            dim_reg       <= DIM_RESET;
            fill_reg      <= '0;
            count_reg     <= '0;
            sticky_reg    <= 1'b0;
            clr_addr_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            second_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= (state_reg == ST_OPS);
            s2_vld_reg <= s1_vld_reg;

            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            else
                clr_addr_reg <= '0;

            if (accept)
            begin
                case (command)
                    CMD_PUSH:
                    begin
                        fill_reg <= push_last ? '0 : fill_eff + IDX_W'(1);
                        i_reg    <= '0;
                        j_reg    <= '0;
                    end
                    CMD_CLEAR:
                    begin
                        fill_reg   <= '0;
                        count_reg  <= '0;
                        sticky_reg <= 1'b0;
                    end
                    default:
                    begin
                        fill_reg <= fill_reg;
                    end
                endcase
            end

            // pair order: (j,i) then (i,j), diagonal closes the row
            if (state_reg == ST_OPS)
            begin
                if (row_done)
                begin
                    i_reg      <= i_reg + IDX_W'(1);
                    j_reg      <= '0;
                    second_reg <= 1'b0;
                end
                else if (second_reg)
                begin
                    j_reg      <= j_reg + IDX_W'(1);
                    second_reg <= 1'b0;
                end
                else
                begin
                    second_reg <= 1'b1;
                end
            end

            if (s2_vld_reg && add_ovf)
                sticky_reg <= 1'b1;

            if ((state_reg == ST_DRAIN) && (state_next == ST_IDLE) && (count_reg != '1))
                count_reg <= count_reg + CNT_W'(1);

            if ((state_reg == ST_READ) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_write && (paddr[2] == REG_DIM_IN_USE))
            begin
                dim_reg  <= pwdata[DIM_CFG_W-1:0];
                fill_reg <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_value   = entry_reg;
    assign vectors_done  = vdone_reg;
    assign overflow_seen = ovf_reg;

`ifndef SYNTHESIS
    a_wb_from_ops: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(state_reg == ST_OPS, 2))
        else $error("sum write-back without an issued update");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OPS) |-> (j_reg <= i_reg))
        else $error("column index passed row index");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (DIM_W'(fill_reg) < act_n))
        else $error("fill index beyond dimension in use");

    a_sticky_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sticky_reg) |-> $past(accept && (command == CMD_CLEAR)))
        else $error("overflow flag dropped without clear");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            ($past(state_reg == ST_DRAIN) || $past(accept && (command == CMD_CLEAR))))
        else $error("vector count changed outside vector end or clear");
`endif

endmodule
